[sv/sibs_pkg.sv]
// Shared types, register codes and reset values of the static IMU bias initializer.
// Depends on nothing; sibs_if, sibs_unit, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package sibs_pkg;

   localparam int SMP_W            = 16;
   localparam int DEF_WINDOW_DEPTH = 1024;

   localparam logic [10:0] RST_WINDOW_CAP  = 11'd1024;
   localparam logic [9:0]  RST_WINDOW_MIN  = 10'd100;
   localparam logic [31:0] RST_STATIC_SPAN = 32'd1000000;
   localparam logic [15:0] RST_STATIC_SPD  = 16'd50;
   localparam logic [14:0] RST_GRAVITY     = 15'd16384;

   typedef enum logic [2:0] {
      REG_WINDOW_CAP,
      REG_WINDOW_MIN,
      REG_STATIC_SPAN,
      REG_STATIC_SPEED,
      REG_GRAVITY
   } sibs_reg_type;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } sibs_op_type;

   typedef struct packed {
      logic        start;
      sibs_op_type op;
   } sibs_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sibs_sts_type;

endpackage

`default_nettype wire

[sv/sibs_if.sv]
// Channel interfaces of the static IMU bias initializer: request, response, register write.
// Depends on sibs_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

interface sibs_req_if;
   import sibs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [31:0]             sample_time;
   logic signed [SMP_W-1:0] gyro_x;
   logic signed [SMP_W-1:0] gyro_y;
   logic signed [SMP_W-1:0] gyro_z;
   logic signed [SMP_W-1:0] acc_x;
   logic signed [SMP_W-1:0] acc_y;
   logic signed [SMP_W-1:0] acc_z;
   logic [15:0]             speed;
   modport source (output valid, operation, sample_time, gyro_x, gyro_y, gyro_z,
                   acc_x, acc_y, acc_z, speed, input ready);
   modport sink   (input valid, operation, sample_time, gyro_x, gyro_y, gyro_z,
                   acc_x, acc_y, acc_z, speed, output ready);
endinterface

interface sibs_rsp_if;
   logic               valid;
   logic               ready;
   logic               ready_res;
   logic [1:0]         axis;
   logic signed [15:0] gyro_bias;
   logic [30:0]        gyro_var;
   logic signed [15:0] gravity;
   logic signed [16:0] acc_bias;
   logic [30:0]        acc_var;
   logic [31:0]        init_time;
   logic               last;
   modport source (output valid, ready_res, axis, gyro_bias, gyro_var, gravity, acc_bias,
                   acc_var, init_time, last, input ready);
   modport sink   (input valid, ready_res, axis, gyro_bias, gyro_var, gravity, acc_bias,
                   acc_var, init_time, last, output ready);
endinterface

interface sibs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/sibs_store.sv]
// Sample window memory: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module sibs_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 128
) (
   input  wire  logic                     clock,
   input  wire  logic                     we,
   input  wire  logic [$clog2(DEPTH)-1:0] waddr,
   input  wire  logic [WIDTH-1:0]         wdata,
   input  wire  logic                     re,
   input  wire  logic [$clog2(DEPTH)-1:0] raddr,
   output logic       [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[sv/sibs_unit.sv]
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, digit square root.
// Depends on sibs_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sibs_unit #(
   parameter int WIDTH = 84
) (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  sibs_pkg::sibs_cmd_type cmd,
   input  wire  logic [WIDTH-1:0]      opd_a,
   input  wire  logic [WIDTH-1:0]      opd_b,
   output sibs_pkg::sibs_sts_type      sts,
   output logic [WIDTH-1:0]            result
);
   import sibs_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   sibs_op_type      op_ff, op_in;
   logic [WIDTH:0]   ra_ff, ra_in;
   logic [WIDTH-1:0] rb_ff, rb_in;
   logic [WIDTH-1:0] rc_ff, rc_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      rc_in   = rc_ff;
      shifted = {ra_ff[WIDTH-1:0], rb_ff[WIDTH-1]};
      trial   = {1'b0, rb_ff} + {1'b0, rc_ff};
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         case (cmd.op)
            OP_SQRT: begin
               ra_in  = {1'b0, opd_a};
               rb_in  = '0;
               rc_in  = WIDTH'(1) << (WIDTH - 2);
               cnt_in = CNT_W'(WIDTH / 2);
            end
            default: begin
               ra_in  = '0;
               rb_in  = opd_a;
               rc_in  = opd_b;
               cnt_in = CNT_W'(WIDTH);
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               if (rc_ff[0]) begin
                  ra_in = ra_ff + {1'b0, rb_ff};
               end
               rb_in = rb_ff << 1;
               rc_in = rc_ff >> 1;
            end
            OP_DIV: begin
               if (shifted >= {1'b0, rc_ff}) begin
                  ra_in = shifted - {1'b0, rc_ff};
                  rb_in = {rb_ff[WIDTH-2:0], 1'b1};
               end else begin
                  ra_in = shifted;
                  rb_in = {rb_ff[WIDTH-2:0], 1'b0};
               end
            end
            OP_SQRT: begin
               if (ra_ff >= trial) begin
                  ra_in = ra_ff - trial;
                  rb_in = (rb_ff >> 1) + rc_ff;
               end else begin
                  rb_in = rb_ff >> 1;
               end
               rc_in = rc_ff >> 2;
            end
            default: begin
               rb_in = rb_ff;
            end
         endcase
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      rc_ff  <= rc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (op_ff == OP_MUL) ? ra_ff[WIDTH-1:0] : rb_ff;

endmodule

`default_nettype wire

[sv/static_imu_bias_initializer.sv]
// Top level of the static IMU bias initializer: sequencer, window sums and result register.
// Depends on sibs_pkg, sibs_if, sibs_store and sibs_unit.
//
//   channel | dir | handshake     | word
//   req_bus | in  | valid / ready | operation, sample_time, gyro_*, acc_*, speed
//   rsp_bus | out | valid / ready | ready_res, axis, statistics, init_time, last
//   csr_bus | in  | valid / ready | index, data (ready always high)
//
// Flow: an odometry word or a rejected sample goes straight to the emit step; an accepted
// sample first drops each old sample over the window cap (one fetch, then one lane per
// cycle through the single squarer). Initialization runs up to 45 operations on the shared
// multiply, divide and square-root unit; an all-zero acceleration sum skips the gravity
// steps and the root.
// Reset is synchronous; the window memory is not cleared, only written entries are read.
// The request side stays open while a finished word waits on rsp_bus; a stalled rsp_bus
// holds the sequencer at its emit step.
`timescale 1ns / 1ps
`default_nettype none

module static_imu_bias_initializer #(
   parameter int WINDOW_DEPTH = sibs_pkg::DEF_WINDOW_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   sibs_req_if.sink   req_bus,
   sibs_rsp_if.source rsp_bus,
   sibs_csr_if.sink   csr_bus
);
   import sibs_pkg::*;

   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int CW    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = SMP_W + $clog2(WINDOW_DEPTH) + 1;
   localparam int SQ_W  = 2 * SMP_W + $clog2(WINDOW_DEPTH);
   localparam int W     = 2 * SUM_W + 30;
   localparam int MEM_W = 6 * SMP_W + 32;
   localparam int ROOT_MAX = 2 ** 15 - 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SINGLE, S_DROP_CHK, S_DROP_SQ, S_ADD_SQ, S_CHK_RD, S_CHK,
      S_TOT_GO, S_TOT_WAIT, S_AX_GO, S_AX_WAIT, S_AX_EMIT
   } state_type;

   typedef enum logic [3:0] {
      ST_GSQ, ST_GNSQ, ST_NN, ST_GVAR, ST_GBIAS, ST_ASQ, ST_ANSQ, ST_AVAR,
      ST_M, ST_P, ST_Y, ST_ROOT, ST_NR, ST_ABIAS
   } step_type;

   // sequencer
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic [2:0] lane_ff, lane_in;
   logic [1:0] axis_ff, axis_in;
   logic       single_rdy_ff, single_rdy_in;

   // window bookkeeping and running sums
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;
   logic signed [SUM_W-1:0] gsum_ff [0:2], gsum_in [0:2];
   logic signed [SUM_W-1:0] asum_ff [0:2], asum_in [0:2];
   logic [SQ_W-1:0] gsq_ff [0:2], gsq_in [0:2];
   logic [SQ_W-1:0] asq_ff [0:2], asq_in [0:2];
   logic static_ff, static_in;
   logic init_ff, init_in;

   // configuration
   logic [10:0] cap_ff, cap_in;
   logic [9:0]  min_ff, min_in;
   logic [31:0] span_ff, span_in;
   logic [15:0] speed_ff, speed_in;
   logic [14:0] grav_ff, grav_in;

   // latched sample
   logic [31:0]             t_ff, t_in;
   logic signed [SMP_W-1:0] smp_ff [0:5], smp_in [0:5];

   // math scratch and per-axis results
   logic [W-1:0] tot_ff, tot_in;
   logic [W-1:0] tmp_ff, tmp_in;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] nn_ff, nn_in;
   logic [14:0]  root_ff, root_in;
   logic [15:0]  gbias_ff, gbias_in;
   logic [30:0]  gvar_ff, gvar_in;
   logic [16:0]  abias_ff, abias_in;
   logic [30:0]  avar_ff, avar_in;

   // result register
   logic        rv_ff, rv_in;
   logic        r_rdy_ff, r_rdy_in;
   logic [1:0]  r_axis_ff, r_axis_in;
   logic [15:0] r_gbias_ff, r_gbias_in;
   logic [30:0] r_gvar_ff, r_gvar_in;
   logic [15:0] r_grav_ff, r_grav_in;
   logic [16:0] r_abias_ff, r_abias_in;
   logic [30:0] r_avar_ff, r_avar_in;
   logic [31:0] r_time_ff, r_time_in;
   logic        r_last_ff, r_last_in;

   // shared unit and memory hookup
   sibs_cmd_type unit_cmd;
   sibs_sts_type unit_sts;
   logic [W-1:0] opd_a, opd_b, unit_res;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [MEM_W-1:0] mem_wdata, mem_rdata;

   // helpers
   logic signed [SMP_W-1:0]   lane_val;
   logic signed [2*SMP_W-1:0] lane_prod;
   logic [1:0]   lane_ax;
   logic         out_free;
   logic [31:0]  cap_wide, cap_sel, slot_wide, next_old;
   logic [CW-1:0] cap_eff;
   logic [W-1:0] n_w, gs_abs, as_abs, sa_w, v_abs, root_w;

   function automatic logic [W-1:0] abs_sum(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] neg;
      neg = -x;
      return (x < 0) ? W'($unsigned(neg)) : W'($unsigned(x));
   endfunction

   sibs_store #(.DEPTH(WINDOW_DEPTH), .WIDTH(MEM_W)) u_store (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
   );

   sibs_unit #(.WIDTH(W)) u_unit (
      .clock(clock), .reset(reset), .cmd(unit_cmd), .opd_a(opd_a), .opd_b(opd_b),
      .sts(unit_sts), .result(unit_res)
   );

   // squarer lane: dropped samples come from the memory read word, new ones from the latch
   assign lane_val  = (state_ff == S_DROP_SQ) ? mem_rdata[SMP_W*lane_ff +: SMP_W]
                                              : smp_ff[lane_ff];
   assign lane_prod = lane_val * lane_val;
   assign lane_ax   = (lane_ff < 3'd3) ? lane_ff[1:0] : 2'(lane_ff - 3'd3);

   // clamp the cap to one .. depth
   assign cap_wide = 32'(cap_ff);
   assign cap_sel  = (cap_wide == 32'd0) ? 32'd1 :
                     (cap_wide > 32'(WINDOW_DEPTH)) ? 32'(WINDOW_DEPTH) : cap_wide;
   assign cap_eff  = cap_sel[CW-1:0];

   assign slot_wide = (32'(oldest_ff) + 32'(held_ff) >= 32'(WINDOW_DEPTH)) ?
                      32'(oldest_ff) + 32'(held_ff) - 32'(WINDOW_DEPTH) :
                      32'(oldest_ff) + 32'(held_ff);
   assign next_old  = (32'(oldest_ff) + 32'd1 >= 32'(WINDOW_DEPTH)) ? 32'd0 :
                      32'(oldest_ff) + 32'd1;

   assign n_w    = W'(held_ff);
   assign gs_abs = abs_sum(gsum_ff[axis_ff]);
   assign as_abs = abs_sum(asum_ff[axis_ff]);
   assign sa_w   = W'(asum_ff[axis_ff]);
   assign v_abs  = tmp_ff[W-1] ? (-tmp_ff) : tmp_ff;
   assign root_w = (unit_res + W'(1)) >> 1;

   assign out_free = !rv_ff || rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      lane_in       = lane_ff;
      axis_in       = axis_ff;
      single_rdy_in = single_rdy_ff;
      oldest_in     = oldest_ff;
      held_in       = held_ff;
      gsum_in       = gsum_ff;
      asum_in       = asum_ff;
      gsq_in        = gsq_ff;
      asq_in        = asq_ff;
      static_in     = static_ff;
      init_in       = init_ff;
      cap_in        = cap_ff;
      min_in        = min_ff;
      span_in       = span_ff;
      speed_in      = speed_ff;
      grav_in       = grav_ff;
      t_in          = t_ff;
      smp_in        = smp_ff;
      tot_in        = tot_ff;
      tmp_in        = tmp_ff;
      num_in        = num_ff;
      nn_in         = nn_ff;
      root_in       = root_ff;
      gbias_in      = gbias_ff;
      gvar_in       = gvar_ff;
      abias_in      = abias_ff;
      avar_in       = avar_ff;
      rv_in         = rv_ff && !rsp_bus.ready;
      r_rdy_in      = r_rdy_ff;
      r_axis_in     = r_axis_ff;
      r_gbias_in    = r_gbias_ff;
      r_gvar_in     = r_gvar_ff;
      r_grav_in     = r_grav_ff;
      r_abias_in    = r_abias_ff;
      r_avar_in     = r_avar_ff;
      r_time_in     = r_time_ff;
      r_last_in     = r_last_ff;
      unit_cmd.start = 1'b0;
      unit_cmd.op    = OP_MUL;
      opd_a     = '0;
      opd_b     = '0;
      mem_we    = 1'b0;
      mem_waddr = slot_wide[AW-1:0];
      mem_wdata = {t_ff, smp_ff[5], smp_ff[4], smp_ff[3], smp_ff[2], smp_ff[1], smp_ff[0]};
      mem_re    = 1'b0;
      mem_raddr = oldest_ff;

      // register writes are taken in any state
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_WINDOW_CAP:   cap_in   = csr_bus.data[10:0];
            REG_WINDOW_MIN:   min_in   = csr_bus.data[9:0];
            REG_STATIC_SPAN:  span_in  = csr_bus.data;
            REG_STATIC_SPEED: speed_in = csr_bus.data[15:0];
            REG_GRAVITY:      grav_in  = csr_bus.data[14:0];
            default:          cap_in   = cap_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               t_in      = req_bus.sample_time;
               smp_in[0] = req_bus.gyro_x;
               smp_in[1] = req_bus.gyro_y;
               smp_in[2] = req_bus.gyro_z;
               smp_in[3] = req_bus.acc_x;
               smp_in[4] = req_bus.acc_y;
               smp_in[5] = req_bus.acc_z;
               if (init_ff) begin
                  single_rdy_in = 1'b1;
                  state_in      = S_SINGLE;
               end else if (req_bus.operation) begin
                  static_in     = req_bus.speed < speed_ff;
                  single_rdy_in = 1'b1;
                  state_in      = S_SINGLE;
               end else if (!static_ff) begin
                  single_rdy_in = 1'b0;
                  state_in      = S_SINGLE;
               end else begin
                  state_in = S_DROP_CHK;
               end
            end
         end
         S_SINGLE: begin
            // word with no statistics: hold until the result register frees up
            if (out_free) begin
               rv_in      = 1'b1;
               r_rdy_in   = single_rdy_ff;
               r_axis_in  = '0;
               r_gbias_in = '0;
               r_gvar_in  = '0;
               r_grav_in  = '0;
               r_abias_in = '0;
               r_avar_in  = '0;
               r_time_in  = '0;
               r_last_in  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DROP_CHK: begin
            // make room: fetch the oldest entry while the window is at or over its cap
            lane_in = '0;
            if (held_ff >= cap_eff) begin
               mem_re   = 1'b1;
               state_in = S_DROP_SQ;
            end else begin
               state_in = S_ADD_SQ;
            end
         end
         S_DROP_SQ: begin
            if (lane_ff < 3'd3) begin
               gsum_in[lane_ax] = gsum_ff[lane_ax] - SUM_W'(lane_val);
               gsq_in[lane_ax]  = gsq_ff[lane_ax] - SQ_W'($unsigned(lane_prod));
            end else begin
               asum_in[lane_ax] = asum_ff[lane_ax] - SUM_W'(lane_val);
               asq_in[lane_ax]  = asq_ff[lane_ax] - SQ_W'($unsigned(lane_prod));
            end
            lane_in = lane_ff + 3'd1;
            if (lane_ff == 3'd5) begin
               oldest_in = next_old[AW-1:0];
               held_in   = held_ff - CW'(1);
               state_in  = S_DROP_CHK;
            end
         end
         S_ADD_SQ: begin
            if (lane_ff < 3'd3) begin
               gsum_in[lane_ax] = gsum_ff[lane_ax] + SUM_W'(lane_val);
               gsq_in[lane_ax]  = gsq_ff[lane_ax] + SQ_W'($unsigned(lane_prod));
            end else begin
               asum_in[lane_ax] = asum_ff[lane_ax] + SUM_W'(lane_val);
               asq_in[lane_ax]  = asq_ff[lane_ax] + SQ_W'($unsigned(lane_prod));
            end
            lane_in = lane_ff + 3'd1;
            if (lane_ff == 3'd5) begin
               mem_we   = 1'b1;
               held_in  = held_ff + CW'(1);
               state_in = S_CHK_RD;
            end
         end
         S_CHK_RD: begin
            // read back the oldest timestamp, which may be the one just written
            mem_re   = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if ((32'(held_ff) > 32'(min_ff)) &&
                ((t_ff - mem_rdata[6*SMP_W +: 32]) >= span_ff)) begin
               init_in  = 1'b1;
               tot_in   = '0;
               axis_in  = '0;
               state_in = S_TOT_GO;
            end else begin
               single_rdy_in = 1'b0;
               state_in      = S_SINGLE;
            end
         end
         S_TOT_GO: begin
            unit_cmd.start = 1'b1;
            unit_cmd.op    = OP_MUL;
            opd_a          = as_abs;
            opd_b          = as_abs;
            state_in       = S_TOT_WAIT;
         end
         S_TOT_WAIT: begin
            if (unit_sts.done) begin
               tot_in = tot_ff + unit_res;
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  step_in  = ST_GSQ;
                  state_in = S_AX_GO;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = S_TOT_GO;
               end
            end
         end
         S_AX_GO: begin
            unit_cmd.start = 1'b1;
            state_in       = S_AX_WAIT;
            case (step_ff)
               ST_GSQ:   begin unit_cmd.op = OP_MUL;  opd_a = gs_abs; opd_b = gs_abs; end
               ST_GNSQ:  begin unit_cmd.op = OP_MUL;  opd_a = n_w; opd_b = W'(gsq_ff[axis_ff]); end
               ST_NN:    begin unit_cmd.op = OP_MUL;  opd_a = n_w;    opd_b = n_w;    end
               ST_GVAR:  begin unit_cmd.op = OP_DIV;  opd_a = num_ff; opd_b = nn_ff;  end
               ST_GBIAS: begin unit_cmd.op = OP_DIV;  opd_a = gs_abs; opd_b = n_w;    end
               ST_ASQ:   begin unit_cmd.op = OP_MUL;  opd_a = as_abs; opd_b = as_abs; end
               ST_ANSQ:  begin unit_cmd.op = OP_MUL;  opd_a = n_w; opd_b = W'(asq_ff[axis_ff]); end
               ST_AVAR:  begin unit_cmd.op = OP_DIV;  opd_a = num_ff; opd_b = nn_ff;  end
               ST_M: begin
                  // an all-zero acceleration sum gives zero gravity: skip the root
                  if (tot_ff == '0) begin
                     unit_cmd.start = 1'b0;
                     root_in        = '0;
                     step_in        = ST_NR;
                     state_in       = S_AX_GO;
                  end else begin
                     unit_cmd.op = OP_MUL;
                     opd_a       = as_abs;
                     opd_b       = W'(grav_ff);
                  end
               end
               ST_P:     begin unit_cmd.op = OP_MUL;  opd_a = tmp_ff; opd_b = tmp_ff; end
               ST_Y:     begin unit_cmd.op = OP_DIV;  opd_a = tmp_ff; opd_b = tot_ff; end
               ST_ROOT:  begin unit_cmd.op = OP_SQRT; opd_a = tmp_ff; end
               ST_NR:    begin unit_cmd.op = OP_MUL;  opd_a = n_w; opd_b = W'(root_ff); end
               ST_ABIAS: begin unit_cmd.op = OP_DIV;  opd_a = v_abs;  opd_b = n_w;    end
               default:  begin unit_cmd.start = 1'b0; state_in = S_IDLE; end
            endcase
         end
         S_AX_WAIT: begin
            if (unit_sts.done) begin
               state_in = S_AX_GO;
               case (step_ff)
                  ST_GSQ: begin
                     tmp_in  = unit_res;
                     step_in = ST_GNSQ;
                  end
                  ST_GNSQ: begin
                     num_in  = (unit_res >= tmp_ff) ? unit_res - tmp_ff : '0;
                     step_in = ST_NN;
                  end
                  ST_NN: begin
                     nn_in   = unit_res;
                     step_in = ST_GVAR;
                  end
                  ST_GVAR: begin
                     gvar_in = unit_res[30:0];
                     step_in = ST_GBIAS;
                  end
                  ST_GBIAS: begin
                     gbias_in = (gsum_ff[axis_ff] < 0) ? 16'(-unit_res) : unit_res[15:0];
                     step_in  = ST_ASQ;
                  end
                  ST_ASQ: begin
                     tmp_in  = unit_res;
                     step_in = ST_ANSQ;
                  end
                  ST_ANSQ: begin
                     num_in  = (unit_res >= tmp_ff) ? unit_res - tmp_ff : '0;
                     step_in = ST_AVAR;
                  end
                  ST_AVAR: begin
                     avar_in = unit_res[30:0];
                     step_in = ST_M;
                  end
                  ST_M: begin
                     tmp_in  = unit_res << 1;
                     step_in = ST_P;
                  end
                  ST_P: begin
                     tmp_in  = unit_res;
                     step_in = ST_Y;
                  end
                  ST_Y: begin
                     tmp_in  = unit_res;
                     step_in = ST_ROOT;
                  end
                  ST_ROOT: begin
                     // round to nearest: largest r with (2r-1)^2 at most the quotient
                     root_in = (root_w > W'(ROOT_MAX)) ? 15'(ROOT_MAX) : root_w[14:0];
                     step_in = ST_NR;
                  end
                  ST_NR: begin
                     tmp_in  = (asum_ff[axis_ff] > 0) ? sa_w - unit_res : sa_w + unit_res;
                     step_in = ST_ABIAS;
                  end
                  ST_ABIAS: begin
                     abias_in = tmp_ff[W-1] ? 17'(-unit_res) : unit_res[16:0];
                     state_in = S_AX_EMIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_AX_EMIT: begin
            if (out_free) begin
               rv_in      = 1'b1;
               r_rdy_in   = 1'b1;
               r_axis_in  = axis_ff;
               r_gbias_in = gbias_ff;
               r_gvar_in  = gvar_ff;
               r_grav_in  = (asum_ff[axis_ff] > 0) ? 16'(-{1'b0, root_ff}) : {1'b0, root_ff};
               r_abias_in = abias_ff;
               r_avar_in  = avar_ff;
               r_time_in  = t_ff;
               r_last_in  = (axis_ff == 2'd2);
               if (axis_ff == 2'd2) begin
                  state_in = S_IDLE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  step_in  = ST_GSQ;
                  state_in = S_AX_GO;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      lane_ff       <= lane_in;
      axis_ff       <= axis_in;
      single_rdy_ff <= single_rdy_in;
      t_ff          <= t_in;
      smp_ff        <= smp_in;
      tot_ff        <= tot_in;
      tmp_ff        <= tmp_in;
      num_ff        <= num_in;
      nn_ff         <= nn_in;
      root_ff       <= root_in;
      gbias_ff      <= gbias_in;
      gvar_ff       <= gvar_in;
      abias_ff      <= abias_in;
      avar_ff       <= avar_in;
      r_rdy_ff      <= r_rdy_in;
      r_axis_ff     <= r_axis_in;
      r_gbias_ff    <= r_gbias_in;
      r_gvar_ff     <= r_gvar_in;
      r_grav_ff     <= r_grav_in;
      r_abias_ff    <= r_abias_in;
      r_avar_ff     <= r_avar_in;
      r_time_ff     <= r_time_in;
      r_last_ff     <= r_last_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         oldest_ff <= '0;
         held_ff   <= '0;
         gsum_ff   <= '{default: '0};
         asum_ff   <= '{default: '0};
         gsq_ff    <= '{default: '0};
         asq_ff    <= '{default: '0};
         static_ff <= 1'b0;
         init_ff   <= 1'b0;
         cap_ff    <= RST_WINDOW_CAP;
         min_ff    <= RST_WINDOW_MIN;
         span_ff   <= RST_STATIC_SPAN;
         speed_ff  <= RST_STATIC_SPD;
         grav_ff   <= RST_GRAVITY;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
         gsum_ff   <= gsum_in;
         asum_ff   <= asum_in;
         gsq_ff    <= gsq_in;
         asq_ff    <= asq_in;
         static_ff <= static_in;
         init_ff   <= init_in;
         cap_ff    <= cap_in;
         min_ff    <= min_in;
         span_ff   <= span_in;
         speed_ff  <= speed_in;
         grav_ff   <= grav_in;
         rv_ff     <= rv_in;
      end
   end

   // accept requests only between items; register writes never stall
   assign req_bus.ready     = (state_ff == S_IDLE);
   assign csr_bus.ready     = 1'b1;

   assign rsp_bus.valid     = rv_ff;
   assign rsp_bus.ready_res = r_rdy_ff;
   assign rsp_bus.axis      = r_axis_ff;
   assign rsp_bus.gyro_bias = r_gbias_ff;
   assign rsp_bus.gyro_var  = r_gvar_ff;
   assign rsp_bus.gravity   = r_grav_ff;
   assign rsp_bus.acc_bias  = r_abias_ff;
   assign rsp_bus.acc_var   = r_avar_ff;
   assign rsp_bus.init_time = r_time_ff;
   assign rsp_bus.last      = r_last_ff;

endmodule

`default_nettype wire

[tb/static_imu_bias_initializer_tb.sv]
// Self-checking testbench of the static IMU bias initializer: directed and random words.
// Depends on sibs_pkg, sibs_if and the static_imu_bias_initializer RTL.
`timescale 1ns / 1ps
`default_nettype none

module static_imu_bias_initializer_tb;
   import sibs_pkg::*;

   localparam int DEPTH       = DEF_WINDOW_DEPTH;
   localparam int STALL_LIMIT = 60000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      bit               op;
      bit [31:0]        stamp;
      bit signed [15:0] gyro[3];
      bit signed [15:0] acc[3];
      bit [15:0]        speed;
   } imu_word_type;

   typedef struct packed {
      logic               ready_res;
      logic [1:0]         axis;
      logic signed [15:0] gyro_bias;
      logic [30:0]        gyro_var;
      logic signed [15:0] gravity;
      logic signed [16:0] acc_bias;
      logic [30:0]        acc_var;
      logic [31:0]        init_time;
      logic               last;
   } bias_stats_type;

   // Window predictor plus the queue of statistics words still owed by the block.
   class bias_window_model;
      bit [10:0]       cap_reg;
      bit [9:0]        min_reg;
      bit [31:0]       span_reg;
      bit [15:0]       speed_reg;
      bit [14:0]       grav_reg;
      longint          gyro_mem[DEPTH][3];
      longint          acc_mem[DEPTH][3];
      bit [31:0]       stamp_mem[DEPTH];
      int              oldest;
      int              held;
      longint          gyro_sum[3], acc_sum[3], gyro_sq[3], acc_sq[3];
      bit              still;
      bit              init_done;
      bias_stats_type  pending_stats[$];
      int              errors;

      function new();
         cap_reg   = RST_WINDOW_CAP;
         min_reg   = RST_WINDOW_MIN;
         span_reg  = RST_STATIC_SPAN;
         speed_reg = RST_STATIC_SPD;
         grav_reg  = RST_GRAVITY;
         oldest    = 0;
         held      = 0;
         still     = 0;
         init_done = 0;
         errors    = 0;
         for (int k = 0; k < 3; k++) begin
            gyro_sum[k] = 0; acc_sum[k] = 0; gyro_sq[k] = 0; acc_sq[k] = 0;
         end
      endfunction

      function void set_reg(sibs_reg_type idx, bit [31:0] v);
         case (idx)
            REG_WINDOW_CAP:   cap_reg   = v[10:0];
            REG_WINDOW_MIN:   min_reg   = v[9:0];
            REG_STATIC_SPAN:  span_reg  = v;
            REG_STATIC_SPEED: speed_reg = v[15:0];
            REG_GRAVITY:      grav_reg  = v[14:0];
            default: ;
         endcase
      endfunction

      function void drop_oldest();
         for (int k = 0; k < 3; k++) begin
            gyro_sum[k] -= gyro_mem[oldest][k];
            gyro_sq[k]  -= gyro_mem[oldest][k] * gyro_mem[oldest][k];
            acc_sum[k]  -= acc_mem[oldest][k];
            acc_sq[k]   -= acc_mem[oldest][k] * acc_mem[oldest][k];
         end
         oldest = (oldest + 1 >= DEPTH) ? 0 : oldest + 1;
         held--;
      endfunction

      function longint pop_var(longint s, longint sq, longint n);
         longint num;
         num = n * sq - s * s;
         if (num < 0) num = 0;
         return num / (n * n);
      endfunction

      // Largest g' with (2g'-1)^2 * total <= (2|s|g)^2: rounds |s|*g/sqrt(total) half up.
      function int grav_mag(longint s, longint unsigned total, longint unsigned g);
         bit [127:0] m, t;
         int lo, hi, mid;
         m  = 128'(s < 0 ? -s : s) * 128'(g) * 2;
         lo = 0;
         hi = 32767;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 128'(2 * mid - 1);
            if (t * t * 128'(total) <= m * m) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function void owe_word(bias_stats_type r);
         pending_stats.insert(pending_stats.size(), r);
      endfunction

      function void push_plain(bit rdy);
         bias_stats_type r;
         r = '0;
         r.ready_res = rdy;
         r.last = 1'b1;
         owe_word(r);
      endfunction

      function void note_word(imu_word_type w);
         int c, slot, g;
         longint n;
         longint unsigned total;
         bias_stats_type r;
         if (init_done) begin
            push_plain(1'b1);
            return;
         end
         if (w.op) begin
            still = w.speed < speed_reg;
            push_plain(1'b1);
            return;
         end
         if (!still) begin
            push_plain(1'b0);
            return;
         end
         c = int'(cap_reg);
         if (c < 1) c = 1;
         if (c > DEPTH) c = DEPTH;
         while (held >= c) drop_oldest();
         slot = (oldest + held) % DEPTH;
         for (int k = 0; k < 3; k++) begin
            gyro_mem[slot][k] = w.gyro[k];
            acc_mem[slot][k]  = w.acc[k];
            gyro_sum[k] += w.gyro[k];
            gyro_sq[k]  += longint'(w.gyro[k]) * w.gyro[k];
            acc_sum[k]  += w.acc[k];
            acc_sq[k]   += longint'(w.acc[k]) * w.acc[k];
         end
         stamp_mem[slot] = w.stamp;
         held++;
         if (!(held > min_reg && (w.stamp - stamp_mem[oldest]) >= span_reg)) begin
            push_plain(1'b0);
            return;
         end
         init_done = 1;
         n = held;
         total = 0;
         for (int k = 0; k < 3; k++) total += longint'(acc_sum[k] * acc_sum[k]);
         for (int k = 0; k < 3; k++) begin
            g = 0;
            if (total != 0) begin
               g = grav_mag(acc_sum[k], total, grav_reg);
               if (acc_sum[k] > 0) g = -g;
            end
            r.ready_res = 1'b1;
            r.axis      = 2'(k);
            r.gyro_bias = 16'(gyro_sum[k] / n);
            r.gyro_var  = 31'(pop_var(gyro_sum[k], gyro_sq[k], n));
            r.gravity   = 16'(g);
            r.acc_bias  = 17'((acc_sum[k] + n * g) / n);
            r.acc_var   = 31'(pop_var(acc_sum[k], acc_sq[k], n));
            r.init_time = w.stamp;
            r.last      = (k == 2);
            owe_word(r);
         end
      endfunction

      function void check_word(bias_stats_type got);
         bias_stats_type want;
         if (pending_stats.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX) $display("unexpected word: %p", got);
            return;
         end
         want = pending_stats[0];
         pending_stats.delete(0);
         if (got.ready_res !== want.ready_res || got.axis !== want.axis ||
             got.gyro_bias !== want.gyro_bias || got.gyro_var !== want.gyro_var ||
             got.gravity !== want.gravity || got.acc_bias !== want.acc_bias ||
             got.acc_var !== want.acc_var || got.init_time !== want.init_time ||
             got.last !== want.last) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("mismatch: expected %p, actual %p", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   quiet_cycles = 0;
   bit [31:0] now_stamp;
   bias_window_model model;

   sibs_req_if req_bus ();
   sibs_rsp_if rsp_bus ();
   sibs_csr_if csr_bus ();

   static_imu_bias_initializer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Randomly stall the result channel at the current phase rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Check every accepted result word; track quiet cycles for the watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         model.check_word({rsp_bus.ready_res, rsp_bus.axis, rsp_bus.gyro_bias,
                           rsp_bus.gyro_var, rsp_bus.gravity, rsp_bus.acc_bias,
                           rsp_bus.acc_var, rsp_bus.init_time, rsp_bus.last});
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Push one register write; hold valid until the block takes it, then drop it.
   task automatic write_reg(sibs_reg_type idx, bit [31:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      model.set_reg(idx, v);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one word after a random gap; valid stays high for a back-to-back word.
   task automatic send_word(imu_word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= w.op;
      req_bus.sample_time <= w.stamp;
      req_bus.gyro_x      <= w.gyro[0];
      req_bus.gyro_y      <= w.gyro[1];
      req_bus.gyro_z      <= w.gyro[2];
      req_bus.acc_x       <= w.acc[0];
      req_bus.acc_y       <= w.acc[1];
      req_bus.acc_z       <= w.acc[2];
      req_bus.speed       <= w.speed;
      do @(posedge clock); while (!req_bus.ready);
      model.note_word(w);
   endtask

   // Hold the sender until every owed word is back, then let the sequencer settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (model.pending_stats.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic imu_word_type speed_word(bit [15:0] s);
      imu_word_type w;
      w.op    = 1'b1;
      w.stamp = $urandom;
      for (int k = 0; k < 3; k++) begin
         w.gyro[k] = 16'($urandom);
         w.acc[k]  = 16'($urandom);
      end
      w.speed = s;
      return w;
   endfunction

   function automatic imu_word_type sample_word(bit signed [15:0] gv, bit signed [15:0] av,
                                                bit [31:0] t);
      imu_word_type w;
      w.op    = 1'b0;
      w.stamp = t;
      for (int k = 0; k < 3; k++) begin
         w.gyro[k] = gv;
         w.acc[k]  = av;
      end
      w.speed = 16'($urandom);
      return w;
   endfunction

   // Mostly plausible static samples near -1 g on z; a quarter full-range noise.
   function automatic imu_word_type random_word();
      imu_word_type w;
      if ($urandom_range(99) < 15)
         return speed_word($urandom_range(99) < 75 ? 16'($urandom_range(0, 49)) : 16'($urandom));
      now_stamp += $urandom_range(1, 5000);
      w = sample_word(0, 0, now_stamp);
      if ($urandom_range(3) == 0) begin
         w.stamp = $urandom;
         for (int k = 0; k < 3; k++) begin
            w.gyro[k] = 16'($urandom);
            w.acc[k]  = 16'($urandom);
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            w.gyro[k] = 16'($urandom_range(0, 400)) - 16'sd200;
            w.acc[k]  = 16'($urandom_range(0, 800)) - 16'sd400;
         end
         w.acc[2] = w.acc[2] - 16'sd16384;
      end
      return w;
   endfunction

   task automatic run_random(int count, int idle, int stall, bit pause_mid);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) drain_results();
         send_word(random_word());
      end
      drain_results();
   endtask

   initial begin
      model         = new();
      reset         = 1'b1;
      idle_pct      = 0;
      stall_pct     = 0;
      now_stamp     = 32'hFFF8_0000;
      req_bus.valid = 1'b0;
      req_bus.operation   = 1'b0;
      req_bus.sample_time = '0;
      req_bus.gyro_x = '0; req_bus.gyro_y = '0; req_bus.gyro_z = '0;
      req_bus.acc_x  = '0; req_bus.acc_y  = '0; req_bus.acc_z  = '0;
      req_bus.speed  = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = REG_WINDOW_CAP;
      csr_bus.data   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: keep initialization out of reach while the window is exercised.
      write_reg(REG_WINDOW_CAP, 4);
      write_reg(REG_WINDOW_MIN, 1023);
      write_reg(REG_STATIC_SPAN, 32'hFFFF_FFFF);
      write_reg(REG_STATIC_SPEED, 0);
      write_reg(REG_GRAVITY, 0);
      send_word(sample_word(1, 1, 0));              // moving after reset: rejected
      send_word(speed_word(0));                     // zero threshold: never static
      send_word(speed_word(16'hFFFF));
      drain_results();
      write_reg(REG_STATIC_SPEED, 16'hFFFF);
      send_word(speed_word(16'hFFFE));              // just under threshold: static
      send_word(speed_word(16'hFFFF));              // at threshold: moving
      send_word(sample_word(2, 2, 5));
      send_word(speed_word(0));
      send_word(sample_word(16'sh8000, 16'sh8000, 32'hFFFF_FFFE));
      send_word(sample_word(16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF));
      send_word(sample_word(0, 0, 0));
      send_word(sample_word(16'sh7FFF, 16'sh8000, 32'h8000_0000));
      send_word(sample_word(16'sh8000, 16'sh7FFF, 32'h7FFF_FFFF));
      send_word(sample_word(-1, -1, 32'h5555_5555));  // window full: oldest dropped
      drain_results();
      write_reg(REG_WINDOW_CAP, 0);                 // acts as a cap of one
      send_word(sample_word(16'sh1234, -16'sh4321, 32'hAAAA_AAAA));
      send_word(sample_word(-16'sh1234, 16'sh4321, 32'hAAAA_AAAB));
      drain_results();
      write_reg(REG_WINDOW_CAP, 11'h7FF);           // beyond depth: clamped
      write_reg(REG_STATIC_SPEED, 50);
      send_word(sample_word(3, 3, 10));
      send_word(sample_word(4, 4, 20));

      // Random phases: let the window grow, then cut the cap below the held count.
      drain_results();
      run_random(60, 0, 0, 1'b0);
      write_reg(REG_WINDOW_CAP, $urandom_range(1, 8));
      run_random(60, 87, 0, 1'b1);
      write_reg(REG_WINDOW_CAP, 1024);
      run_random(60, 0, 87, 1'b0);
      write_reg(REG_WINDOW_CAP, $urandom_range(2, 40));
      run_random(50, 28, 28, 1'b0);

      // Open the gate: go static, relax count and span, and run past initialization.
      write_reg(REG_WINDOW_CAP, 1024);
      write_reg(REG_WINDOW_MIN, $urandom_range(0, 20));
      write_reg(REG_STATIC_SPAN, $urandom_range(0, 2000));
      write_reg(REG_GRAVITY, $urandom_range(0, 99) < 50 ? 32'd16384 : 32'h7FFF);
      idle_pct  = 28;
      stall_pct = 28;
      send_word(speed_word(0));
      while (!model.init_done) send_word(random_word());
      for (int i = 0; i < 12; i++) send_word(random_word());
      send_word(speed_word(16'hFFFF));              // ignored once initialized
      drain_results();

      if (model.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
sv/sibs_pkg.sv
sv/sibs_if.sv
sv/sibs_store.sv
sv/sibs_unit.sv
sv/static_imu_bias_initializer.sv
tb/static_imu_bias_initializer_tb.sv
